FILE: src/aglb_pkg.sv
// ----------------------------------------------------------------------------
// aglb_pkg
// Shared types and constants of the antialiased glyph blend core: beat
// payloads, configuration register codes, filter weights and store sizes.
// ----------------------------------------------------------------------------
package aglb_pkg;

  localparam int MAX_ROW = 256;
  localparam int ADDR_W  = $clog2(MAX_ROW);
  localparam int LEN_W   = $clog2(MAX_ROW + 1);
  localparam int ROW_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [ROW_W-1:0] ROW_SAT  = 9'd511;
  localparam logic [11:0]      W_CENTRE = 12'd1234;
  localparam logic [11:0]      W_EDGE   = 12'd507;
  localparam logic [11:0]      W_CORNER = 12'd208;
  localparam logic [12:0]      ONE_Q12  = 13'd4096;
  localparam logic [7:0]       INK_RESET = 8'd255;
  localparam logic [8:0]       ROW_LENGTH_RESET = 9'd16;
  localparam logic [8:0]       ROW_LENGTH_MIN = 9'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INK_RED    = 2'd0,
    REG_INK_GREEN  = 2'd1,
    REG_INK_BLUE   = 2'd2,
    REG_ROW_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       glyph_bit;
    logic       first_of_glyph;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [11:0] coverage_level;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // line store entry: bit 1 row r-2, bit 0 row r-1
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [1:0]        wr_data;
  } ls_req_t;

endpackage

FILE: src/aglb_if.sv
// ----------------------------------------------------------------------------
// aglb channel interfaces
// Valid/ready channels for input samples, blended pixels and register writes.
// ----------------------------------------------------------------------------
interface aglb_in_if import aglb_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aglb_out_if import aglb_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aglb_cfg_if import aglb_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/aglb_line_store.sv
// ----------------------------------------------------------------------------
// aglb_line_store
// Two-row line store: one synchronous memory of two-bit entries with one
// read and one write port, per-entry valid bits cleared at reset and
// forwarding of a write that lands on the entry read at the same edge.
// ----------------------------------------------------------------------------
module aglb_line_store import aglb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ls_req_t    req,
  output logic [1:0] rd_data
);

  logic [1:0]         line_mem_r [MAX_ROW];
  logic [MAX_ROW-1:0] vld_r;
  logic [1:0]         rd_q_r;
  logic               rd_vld_r;
  logic               fwd_hit_r;
  logic [1:0]         fwd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      line_mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r     <= line_mem_r[req.rd_addr];
      fwd_data_r <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r  <= vld_r[req.rd_addr];
        fwd_hit_r <= req.wr_en && (req.wr_addr == req.rd_addr);
      end
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : (rd_vld_r ? rd_q_r : 2'b00);

endmodule

FILE: src/antialiased_glyph_blend_core.sv
// ----------------------------------------------------------------------------
// antialiased_glyph_blend_core
// 3x3 Gaussian coverage filter over a streamed 1-bit glyph bitmap with
// alpha blending of the ink colour onto the background.
// ----------------------------------------------------------------------------
// The core takes one bitmap sample per clock unless the output holds it off
// and emits one blended pixel per sample once the 3x3 window is full (from
// the third row and third column of each glyph); a pixel moves through the
// sample, window and output registers. The line store, a single memory of
// MAX_ROW two-bit entries, is read in the accept cycle and written back when
// the sample leaves the window stage; a write to the entry read in the same
// cycle is forwarded. Per-entry valid bits clear the store at reset, so no
// clearing pass is needed. Register writes are taken every cycle and belong
// between glyph streams while the core is idle.
module antialiased_glyph_blend_core import aglb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  aglb_in_if.sink  in_ch,
  aglb_out_if.source out_ch,
  aglb_cfg_if.sink cfg_ch
);

  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    return (r < ROW_SAT) ? r + 1'b1 : r;
  endfunction

  function automatic logic [11:0] cov_calc(input logic [2:0] p2, input logic [2:0] p1,
                                           input logic [2:0] col);
    logic [2:0] corners;
    logic [2:0] edges;
    corners = 3'(p2[2]) + 3'(p2[0]) + 3'(col[2]) + 3'(col[0]);
    edges   = 3'(p1[2]) + 3'(p1[0]) + 3'(p2[1]) + 3'(col[1]);
    return 12'(corners) * W_CORNER + 12'(edges) * W_EDGE + (p1[1] ? W_CENTRE : 12'd0);
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] ink, input logic [11:0] a,
                                       input logic [7:0] bg);
    logic [12:0] inv;
    logic [20:0] sum;
    inv = ONE_Q12 - {1'b0, a};
    sum = {13'd0, ink} * {9'd0, a} + {13'd0, bg} * {8'd0, inv};
    return sum[19:12];
  endfunction

  // configuration
  logic [7:0] ink_red_r, ink_green_r, ink_blue_r;
  logic [8:0] row_length_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ink_red_r    <= INK_RESET;
      ink_green_r  <= INK_RESET;
      ink_blue_r   <= INK_RESET;
      row_length_r <= ROW_LENGTH_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_INK_RED:    ink_red_r    <= cfg_ch.data[7:0];
        REG_INK_GREEN:  ink_green_r  <= cfg_ch.data[7:0];
        REG_INK_BLUE:   ink_blue_r   <= cfg_ch.data[7:0];
        REG_ROW_LENGTH: row_length_r <= cfg_ch.data[8:0];
        default: ;
      endcase
    end
  end

  // pipeline state
  logic [LEN_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              b_v_r, b_emit_r, b_clr_r, b_bit_r;
  logic [ADDR_W-1:0] b_addr_r;
  rgb_t              b_bg_r;
  logic [5:0]        window_r;
  logic              c_v_r;
  logic [11:0]       c_cov_r;
  rgb_t              c_bg_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  // sample position
  logic [LEN_W-1:0] len_eff, c0, c_a, c1;
  logic [ROW_W-1:0] r0, r_a;
  logic             accept, emit_a;

  always_comb begin
    if (row_length_r < ROW_LENGTH_MIN) begin
      len_eff = LEN_W'(ROW_LENGTH_MIN);
    end else if (int'(row_length_r) > MAX_ROW) begin
      len_eff = LEN_W'(MAX_ROW);
    end else begin
      len_eff = LEN_W'(row_length_r);
    end
    c0 = in_ch.data.first_of_glyph ? '0 : col_r;
    r0 = in_ch.data.first_of_glyph ? '0 : row_r;
    if (c0 >= len_eff) begin
      c_a = '0;
      r_a = row_inc(r0);
    end else begin
      c_a = c0;
      r_a = r0;
    end
    c1 = c_a + 1'b1;
    if (c1 >= len_eff) begin
      col_nxt = '0;
      row_nxt = row_inc(r_a);
    end else begin
      col_nxt = c1;
      row_nxt = r_a;
    end
    emit_a = (r_a >= ROW_W'(2)) && (c_a >= LEN_W'(2));
  end

  // flow control
  logic out_free, c_move, c_free, b_move;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign c_move      = c_v_r && out_free;
  assign c_free      = !c_v_r || c_move;
  assign b_move      = b_v_r && (!b_emit_r || c_free);
  assign in_ch.ready = !b_v_r || b_move;
  assign accept      = in_ch.valid && in_ch.ready;

  // line store
  ls_req_t    ls_req;
  logic [1:0] ls_rd;

  assign ls_req.rd_en   = accept;
  assign ls_req.rd_addr = c_a[ADDR_W-1:0];
  assign ls_req.wr_en   = b_move;
  assign ls_req.wr_addr = b_addr_r;
  assign ls_req.wr_data = {ls_rd[0], b_bit_r};

  aglb_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ls_req),
    .rd_data (ls_rd)
  );

  // window and coverage
  logic [2:0]  col_b;
  logic [5:0]  prev_b;
  logic [11:0] cov_b;

  assign col_b  = {ls_rd[1], ls_rd[0], b_bit_r};
  assign prev_b = b_clr_r ? 6'd0 : window_r;
  assign cov_b  = cov_calc(prev_b[5:3], prev_b[2:0], col_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= '0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (b_move) begin
        window_r <= {prev_b[2:0], col_b};
      end
      b_v_r       <= (b_v_r && !b_move) || accept;
      c_v_r       <= (c_v_r && !c_move) || (b_move && b_emit_r);
      out_valid_r <= (out_valid_r && !out_ch.ready) || c_move;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_addr_r     <= c_a[ADDR_W-1:0];
      b_bit_r      <= in_ch.data.glyph_bit;
      b_emit_r     <= emit_a;
      b_clr_r      <= (c_a == '0);
      b_bg_r.red   <= in_ch.data.bg_red;
      b_bg_r.green <= in_ch.data.bg_green;
      b_bg_r.blue  <= in_ch.data.bg_blue;
    end
    if (b_move && b_emit_r) begin
      c_cov_r <= cov_b;
      c_bg_r  <= b_bg_r;
    end
    if (c_move) begin
      out_data_r.out_red        <= blend(ink_red_r, c_cov_r, c_bg_r.red);
      out_data_r.out_green      <= blend(ink_green_r, c_cov_r, c_bg_r.green);
      out_data_r.out_blue       <= blend(ink_blue_r, c_cov_r, c_bg_r.blue);
      out_data_r.coverage_level <= c_cov_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_col_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    int'(col_r) < MAX_ROW)
    else $error("column count beyond line store depth");

  a_cov_bound: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r |-> (c_cov_r <= 12'd4094))
    else $error("coverage above full weight sum");

  a_first_at_col0: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.first_of_glyph) |=> (b_v_r && b_addr_r == '0 && b_clr_r && !b_emit_r))
    else $error("new glyph sample not placed at column zero");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && b_emit_r && !c_free) |-> !accept)
    else $error("sample accepted while window stage is stalled");
`endif

endmodule

FILE: bench/aglb_blend_checker.sv
// ----------------------------------------------------------------------------
// aglb_blend_checker
// Watches the sample, pixel and register channels of the glyph blend core.
// Keeps its own line stores, window and counters, and works out the blended
// pixel for every accepted sample that completes a 3x3 window. Each pixel
// beat is compared field by field with the oldest pixel still awaited.
// ----------------------------------------------------------------------------
module aglb_blend_checker import aglb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  aglb_in_if   in_ch,
  aglb_out_if  out_ch,
  aglb_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  logic [7:0] ink_red;
  logic [7:0] ink_green;
  logic [7:0] ink_blue;
  logic [8:0] row_length;

  logic        line_above  [MAX_ROW];
  logic        line_middle [MAX_ROW];
  logic [5:0]  window_bits;
  int unsigned col_cnt;
  int unsigned row_cnt;

  out_item_t pixel_queue[$];

  function automatic logic [7:0] blend_channel(logic [7:0] ink, int unsigned cov,
                                               logic [7:0] bg);
    int unsigned mixed;
    mixed = (int'(ink) * cov + (ONE_Q12 - cov) * int'(bg)) >> 12;
    return mixed[7:0];
  endfunction

  function automatic void close_row();
    col_cnt = 0;
    if (row_cnt < ROW_SAT) row_cnt++;
    window_bits = '0;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic filter_sample(in_item_t s);
    int unsigned len;
    int unsigned c;
    int unsigned corners;
    int unsigned edges;
    int unsigned centre;
    int unsigned cov;
    logic [2:0]  col;
    logic [2:0]  prev1;
    logic [2:0]  prev2;
    out_item_t   px;
    len = (row_length < ROW_LENGTH_MIN) ? ROW_LENGTH_MIN :
          ((row_length > MAX_ROW) ? MAX_ROW : row_length);
    if (s.first_of_glyph) begin
      col_cnt = 0;
      row_cnt = 0;
      window_bits = '0;
    end
    if (col_cnt >= len) close_row();
    c = col_cnt;
    col = {line_above[c], line_middle[c], s.glyph_bit};
    prev1 = window_bits[2:0];
    prev2 = window_bits[5:3];
    if (row_cnt >= 2 && c >= 2) begin
      corners = int'(prev2[2]) + int'(prev2[0]) + int'(col[2]) + int'(col[0]);
      edges   = int'(prev1[2]) + int'(prev1[0]) + int'(prev2[1]) + int'(col[1]);
      centre  = int'(prev1[1]);
      cov = corners * W_CORNER + edges * W_EDGE + centre * W_CENTRE;
      px.out_red        = blend_channel(ink_red, cov, s.bg_red);
      px.out_green      = blend_channel(ink_green, cov, s.bg_green);
      px.out_blue       = blend_channel(ink_blue, cov, s.bg_blue);
      px.coverage_level = cov[11:0];
      pixel_queue.push_back(px);
    end
    line_above[c]  = line_middle[c];
    line_middle[c] = s.glyph_bit;
    window_bits    = {prev1, col};
    col_cnt = c + 1;
    if (col_cnt >= len) close_row();
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ink_red    = INK_RESET;
      ink_green  = INK_RESET;
      ink_blue   = INK_RESET;
      row_length = ROW_LENGTH_RESET;
      for (int i = 0; i < MAX_ROW; i++) begin
        line_above[i]  = 1'b0;
        line_middle[i] = 1'b0;
      end
      window_bits = '0;
      col_cnt = 0;
      row_cnt = 0;
      pixel_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_INK_RED:    ink_red    = cfg_ch.data[7:0];
          REG_INK_GREEN:  ink_green  = cfg_ch.data[7:0];
          REG_INK_BLUE:   ink_blue   = cfg_ch.data[7:0];
          REG_ROW_LENGTH: row_length = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) filter_sample(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_queue.size() == 0) begin
          $error("pixel beat with no pixel awaited");
          fail_count++;
        end else begin
          want = pixel_queue.pop_front();
          check_field("out_red", 32'(want.out_red), 32'(out_ch.data.out_red));
          check_field("out_green", 32'(want.out_green), 32'(out_ch.data.out_green));
          check_field("out_blue", 32'(want.out_blue), 32'(out_ch.data.out_blue));
          check_field("coverage_level", 32'(want.coverage_level),
                      32'(out_ch.data.coverage_level));
        end
      end
    end
    pending = pixel_queue.size();
  end

endmodule

FILE: bench/tb_antialiased_glyph_blend_core.sv
// ----------------------------------------------------------------------------
// tb_antialiased_glyph_blend_core
// Streams padded and unpadded glyph bitmaps, broken glyphs and noise into the
// blend core under random sender and receiver gaps, changes the ink colour
// and row length between streams, and lets the checker compare every pixel.
// ----------------------------------------------------------------------------
module tb_antialiased_glyph_blend_core;
  import aglb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_STALL     = 300;
  localparam int DRAIN_CYCLES   = 8;

  logic clk = 1'b0;
  logic rst_n;

  aglb_in_if  in_ch();
  aglb_out_if out_ch();
  aglb_cfg_if cfg_ch();

  int fail_count;
  int pending;

  int         in_idle_pct;
  int         out_idle_pct;
  int         samples_sent;
  logic [8:0] row_len_reg;
  int         long_stall_req;
  int         long_stall_seen;
  int         stall_left;
  int         quiet_cycles;

  antialiased_glyph_blend_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  aglb_blend_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // receiver: random gaps, plus one long hold-off on request
  always @(negedge clk) begin
    if (long_stall_req != long_stall_seen) begin
      long_stall_seen = long_stall_req;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_sample(logic g, logic f);
    in_item_t s;
    s.glyph_bit      = g;
    s.first_of_glyph = f;
    s.bg_red         = 8'($urandom_range(255));
    s.bg_green       = 8'($urandom_range(255));
    s.bg_blue        = 8'($urandom_range(255));
    return s;
  endfunction

  function automatic logic [8:0] random_ink();
    logic [7:0] ink;
    if ($urandom_range(3) == 0) ink = $urandom_range(1) ? 8'd255 : 8'd0;
    else ink = 8'($urandom_range(255));
    return {1'($urandom_range(1)), ink};
  endfunction

  task automatic send_sample(in_item_t s);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  // drop valid, wait for every pixel and for the pipeline to empty
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [8:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_ROW_LENGTH) row_len_reg = value;
  endtask

  task automatic send_glyph(int rows, int density, bit padded, bit truncated);
    int   len;
    int   stop;
    int   n;
    logic in_body;
    len = (row_len_reg < ROW_LENGTH_MIN) ? ROW_LENGTH_MIN :
          ((row_len_reg > MAX_ROW) ? MAX_ROW : row_len_reg);
    stop = truncated ? $urandom_range(1, rows * len - 1) : rows * len;
    n = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < len; c++) begin
        if (n == stop) return;
        in_body = !padded || (r >= 2 && r < rows - 2 && c >= 2 && c < len - 2);
        send_sample(make_sample(in_body && ($urandom_range(99) < density), n == 0));
        n++;
      end
    end
  endtask

  task automatic run_phase(int budget, int in_pct, int out_pct);
    int stop_at;
    int pick;
    int density;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    stop_at = samples_sent + budget;
    while (samples_sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        settle();
        if ($urandom_range(1)) write_reg(REG_INK_RED, random_ink());
        if ($urandom_range(1)) write_reg(REG_INK_GREEN, random_ink());
        if ($urandom_range(1)) write_reg(REG_INK_BLUE, random_ink());
        pick = $urandom_range(99);
        if (pick < 60) write_reg(REG_ROW_LENGTH, 9'($urandom_range(3, 12)));
        else if (pick < 70) write_reg(REG_ROW_LENGTH, 9'($urandom_range(0, 2)));
        else if (pick < 85) write_reg(REG_ROW_LENGTH, 9'($urandom_range(13, 40)));
      end
      if ($urandom_range(2) == 0) density = $urandom_range(1) ? 100 : 0;
      else density = $urandom_range(100);
      pick = $urandom_range(9);
      if (pick == 0) begin
        // noise, mostly continuing whatever row is open
        repeat ($urandom_range(1, 40))
          send_sample(make_sample(1'($urandom_range(1)), $urandom_range(19) == 0));
      end else begin
        send_glyph($urandom_range(3, 9), density, 1'($urandom_range(1)), pick == 1);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_INK_RED;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    samples_sent = 0;
    row_len_reg  = ROW_LENGTH_RESET;
    long_stall_req  = 0;
    long_stall_seen = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ink extremes, bit 8 of the data ignored for ink
    write_reg(REG_INK_RED, 9'h0ff);
    write_reg(REG_INK_GREEN, 9'h100);
    write_reg(REG_INK_BLUE, 9'd128);
    write_reg(REG_ROW_LENGTH, 9'd3);
    // full coverage with background extremes
    for (int i = 0; i < 9; i++) begin
      in_item_t s;
      s = make_sample(1'b1, i == 0);
      s.bg_red   = (i % 2) ? 8'd255 : 8'd0;
      s.bg_green = (i % 2) ? 8'd0 : 8'd255;
      s.bg_blue  = (i % 2) ? 8'd255 : 8'd0;
      send_sample(s);
    end
    // new glyph, then the row length is lowered under the open row
    settle();
    write_reg(REG_ROW_LENGTH, 9'd6);
    for (int i = 0; i < 5; i++) send_sample(make_sample(1'b1, i == 0));
    settle();
    write_reg(REG_ROW_LENGTH, 9'd4);
    repeat (8) send_sample(make_sample(1'($urandom_range(1)), 1'b0));

    run_phase(250, 33, 76);

    // widest rows, length written above the maximum
    in_idle_pct  = 76;
    out_idle_pct = 33;
    settle();
    write_reg(REG_ROW_LENGTH, 9'd511);
    send_glyph(3, 50, 1'b0, 1'b0);
    run_phase(100, 76, 33);

    // tall glyph with the shortest rows while the receiver holds off
    in_idle_pct  = 0;
    out_idle_pct = 0;
    settle();
    write_reg(REG_ROW_LENGTH, 9'd1);
    long_stall_req++;
    send_glyph(40, 50, 1'b0, 1'b0);
    run_phase(100, 0, 0);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
